FILE: hdl/json_key_string_extractor_unit_defines.svh
// Assertion macros for the JSON key string extractor.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef JSON_KEY_STRING_EXTRACTOR_UNIT_DEFINES_SVH
`define JSON_KEY_STRING_EXTRACTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define JKSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset
`define JKSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define JKSE_ASSERT_NOW(lbl, ante, cons, msg)
`define JKSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/jkse_pkg.sv
// Shared types, character codes and helpers for the JSON key string extractor.
// No dependencies; imported by every module of the block.
`default_nettype none
package jkse_pkg;

	localparam int KEY_MAX = 32;
	localparam int OUT_MAX = 256;

	// Character codes
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;

	// Configuration register indexes
	localparam logic [2:0] REG_KEY_LEN = 3'd0;
	localparam logic [2:0] REG_KEY_B0  = 3'd1;
	localparam logic [2:0] REG_KEY_B1  = 3'd2;
	localparam logic [2:0] REG_KEY_B2  = 3'd3;
	localparam logic [2:0] REG_KEY_B3  = 3'd4;
	localparam logic [2:0] REG_MAX_LEN = 3'd5;

	typedef enum logic [2:0] {
		PH_SCAN,
		PH_KEY,
		PH_AFTER_KEY,
		PH_AFTER_COLON,
		PH_VALUE,
		PH_ESCAPE
	} phase_t;

	// One classified document byte
	typedef struct packed {
		logic [7:0] data;
		logic       ending;
		logic       zero;
		logic       quote;
		logic       colon;
		logic       ws;
		logic       bslash;
	} item_t;

	// Character limit: max_len clamped to 1..OUT_MAX, minus one, capped at 255
	function automatic logic [7:0] char_limit(input logic [8:0] max_len);
		logic [16:0] cap;
		cap = {8'd0, max_len};
		if (cap == 17'd0) cap = 17'd1;
		if (cap > 17'(OUT_MAX)) cap = 17'(OUT_MAX);
		cap = cap - 17'd1;
		if (cap > 17'd255) cap = 17'd255;
		return cap[7:0];
	endfunction

endpackage
`default_nettype wire

FILE: hdl/jkse_front.sv
// Front end: accepts document bytes and classifies them into a register stage.
// Depends on jkse_pkg.
`default_nettype none
module jkse_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_data,
	input  wire logic          in_last,
	output logic               push,
	output jkse_pkg::item_t    push_item,
	input  wire logic          q_ready
);
	import jkse_pkg::*;

	logic  vld_s1;
	item_t item_s1;
	item_t cls;

	// Classify the incoming byte
	always_comb begin
		cls.data   = in_data;
		cls.zero   = (in_data == 8'd0);
		cls.ending = (in_data == 8'd0) || in_last;
		cls.quote  = (in_data == CH_QUOTE);
		cls.colon  = (in_data == CH_COLON);
		cls.bslash = (in_data == CH_BSLASH);
		cls.ws     = in_data inside {CH_SP, CH_TAB, CH_LF, CH_CR};
	end

	assign in_ready  = !vld_s1 || q_ready;
	assign push      = vld_s1 && q_ready;
	assign push_item = item_s1;

	// Advance the stage whenever it is empty or drains into the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/jkse_queue.sv
// Short FIFO of classified bytes between the front end and the back end.
// Depends on jkse_pkg.
`default_nettype none
module jkse_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire jkse_pkg::item_t push_item,
	output logic               ready,
	input  wire logic          pop,
	output logic               valid,
	output jkse_pkg::item_t    head
);
	import jkse_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign ready = (count_q != CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/jkse_back.sv
// Back end: key matching and value extraction state machine with result register.
// Depends on jkse_pkg.
`default_nettype none
module jkse_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire jkse_pkg::item_t item,
	output logic                q_pop,
	input  wire logic [5:0]     key_len,
	input  wire logic [255:0]   key,
	input  wire logic [8:0]     max_len,
	output logic                res_valid,
	input  wire logic           res_ready,
	output logic [7:0]          res_byte,
	output logic                res_out_valid,
	output logic                res_done,
	output logic                res_found,
	output logic [7:0]          res_length
);
	import jkse_pkg::*;

	phase_t     phase_q, phase_d;
	logic [5:0] kidx_q, kidx_d;
	logic       kmis_q, kmis_d;
	logic [7:0] cnt_q, cnt_d;
	logic       fin_q, fin_d;

	logic       emit, done, found, res;
	logic [7:0] ch;
	logic [7:0] cnt_inc;
	logic [7:0] kbyte;
	logic [7:0] limit;
	logic       klen_ok;

	assign q_pop   = q_valid && (!res_valid || res_ready);
	assign kbyte   = key[{kidx_q[4:0], 3'b000} +: 8];
	assign limit   = char_limit(max_len);
	assign klen_ok = (key_len != 6'd0) && (key_len <= 6'(KEY_MAX));
	assign cnt_inc = cnt_q + 8'd1;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			kidx_q  <= '0;
			kmis_q  <= 1'b0;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			kidx_q  <= kidx_d;
			kmis_q  <= kmis_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
		end
	end

	// Next state and result for the byte at the queue head
	always_comb begin
		phase_d = phase_q;
		kidx_d  = kidx_q;
		kmis_d  = kmis_q;
		cnt_d   = cnt_q;
		fin_d   = fin_q;
		emit    = 1'b0;
		done    = 1'b0;
		ch      = 8'd0;
		found   = 1'b0;
		res     = 1'b0;
		if (q_pop) begin
			if (fin_q) begin
				// Ignore bytes until the document ends
				if (item.ending) begin
					phase_d = PH_SCAN;
					kidx_d  = '0;
					kmis_d  = 1'b0;
					cnt_d   = '0;
					fin_d   = 1'b0;
				end
			end else begin
				if (!item.zero) begin
					case (phase_q)
						PH_SCAN: begin
							if (item.quote) begin
								phase_d = PH_KEY;
								kidx_d  = '0;
								kmis_d  = 1'b0;
							end
						end
						PH_KEY: begin
							if (item.quote) begin
								phase_d = (klen_ok && !kmis_q && kidx_q == key_len) ?
									PH_AFTER_KEY : PH_SCAN;
							end else if (klen_ok && kidx_q < key_len) begin
								if (item.data != kbyte) kmis_d = 1'b1;
								kidx_d = kidx_q + 6'd1;
							end else begin
								kmis_d = 1'b1;
							end
						end
						PH_AFTER_KEY: begin
							if (item.colon) begin
								phase_d = PH_AFTER_COLON;
							end else if (!item.ws) begin
								phase_d = PH_SCAN;
							end
						end
						PH_AFTER_COLON: begin
							if (item.quote) begin
								phase_d = PH_VALUE;
								if (limit == 8'd0) done = 1'b1;
							end else if (!item.ws) begin
								done = 1'b1;
							end
						end
						PH_VALUE: begin
							if (item.quote) begin
								done = 1'b1;
							end else if (item.bslash) begin
								phase_d = PH_ESCAPE;
							end else begin
								emit = 1'b1;
								ch   = item.data;
							end
						end
						PH_ESCAPE: begin
							phase_d = PH_VALUE;
							emit    = 1'b1;
							if (item.data == CH_N) begin
								ch = CH_LF;
							end else if (item.data == CH_T) begin
								ch = CH_TAB;
							end else begin
								ch = item.data;
							end
						end
						default: begin
							phase_d = PH_SCAN;
						end
					endcase
					if (emit) begin
						cnt_d = cnt_inc;
						if (cnt_inc >= limit) done = 1'b1;
					end
				end
				if (item.ending) done = 1'b1;
				found = (phase_d == PH_VALUE) || (phase_d == PH_ESCAPE);
				res   = emit || done;
				if (item.ending) begin
					phase_d = PH_SCAN;
					kidx_d  = '0;
					kmis_d  = 1'b0;
					cnt_d   = '0;
					fin_d   = 1'b0;
				end else begin
					fin_d = done;
				end
			end
		end
	end

	// Result register: drop on take, load on a new result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (res) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res) begin
			res_byte      <= ch;
			res_out_valid <= emit;
			res_done      <= done;
			res_found     <= found;
			res_length    <= emit ? cnt_inc : cnt_q;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/json_key_string_extractor_unit.sv
// Top level of the JSON key string extractor: configuration registers and wiring.
// Depends on jkse_pkg, jkse_front, jkse_queue, jkse_back and the defines header.
//
// Scans a JSON document arriving one byte per transaction on the slave stream and
// returns the string value of the first key that matches the configured key and is
// followed by a colon. The block sustains one byte per clock while the result side
// does not stall: each byte is registered in the classifier stage, then held in a
// QUEUE_DEPTH-entry queue (longer while the result side stalls), and is retired by the
// matching state machine, which updates its state once per byte and so sets the rate.
// Each emitted character and the single ending result of each document come out as
// one master transaction; tlast marks that ending result.
// Configuration may only be written while the block is idle.
`default_nettype none
`include "json_key_string_extractor_unit_defines.svh"
module json_key_string_extractor_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Document bytes
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  wire logic        s_axis_tlast,   // end_of_doc
	// Results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [15:8] length
	output logic [1:0]       m_axis_tuser,   // [0] out_valid, [1] value_found
	output logic             m_axis_tlast,   // done_res
	// Configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata
);
	import jkse_pkg::*;

	logic [5:0]   key_len_q;
	logic [255:0] key_q;
	logic [8:0]   max_len_q;

	logic         push;
	item_t        push_item;
	logic         q_ready;
	logic         q_valid;
	logic         q_pop;
	item_t        head;

	logic [7:0]   res_byte;
	logic [7:0]   res_length;
	logic         res_out_valid;
	logic         res_found;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= 6'd1;
			key_q     <= '0;
			max_len_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_LEN: key_len_q        <= cfg_wdata[5:0];
				REG_KEY_B0:  key_q[63:0]      <= cfg_wdata;
				REG_KEY_B1:  key_q[127:64]    <= cfg_wdata;
				REG_KEY_B2:  key_q[191:128]   <= cfg_wdata;
				REG_KEY_B3:  key_q[255:192]   <= cfg_wdata;
				REG_MAX_LEN: max_len_q        <= cfg_wdata[8:0];
				default: begin
				end
			endcase
		end
	end

	jkse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready)
	);

	jkse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (head)
	);

	jkse_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.item          (head),
		.q_pop         (q_pop),
		.key_len       (key_len_q),
		.key           (key_q),
		.max_len       (max_len_q),
		.res_valid     (m_axis_tvalid),
		.res_ready     (m_axis_tready),
		.res_byte      (res_byte),
		.res_out_valid (res_out_valid),
		.res_done      (m_axis_tlast),
		.res_found     (res_found),
		.res_length    (res_length)
	);

	// Pack result fields
	assign m_axis_tdata = {res_length, res_byte};
	assign m_axis_tuser = {res_found, res_out_valid};

	// An emitted character always belongs to a found value
	`JKSE_ASSERT_NOW(a_char_has_value, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[1], "character without value")
	// A result without a value is an empty ending result
	`JKSE_ASSERT_NOW(a_no_value_empty, m_axis_tvalid && !m_axis_tuser[1], m_axis_tlast && !m_axis_tuser[0] && m_axis_tdata[15:8] == 8'd0, "bad result without value")
	// Hold the queue while the result register is stalled
	`JKSE_ASSERT_NOW(a_no_pop_stalled, m_axis_tvalid && !m_axis_tready, !q_pop, "queue popped while result stalled")
	// A stalled result register stays loaded in the next cycle
	`JKSE_ASSERT_NEXT(a_result_kept, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "stalled result lost")

endmodule
`default_nettype wire

FILE: verif/tb_json_key_string_extractor_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for json_key_string_extractor_unit: streams JSON documents,
// predicts every extracted character and ending result, and checks them in order.
// Depends on jkse_pkg and the RTL of the block only.
module tb_json_key_string_extractor_unit;
	import jkse_pkg::*;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_DIGIT0 = 8'h30;
	localparam int LONG_HOLD_CYCLES  = 300;
	localparam int SETTLE_CYCLES     = 10;

	// One result as the block should present it
	typedef struct {
		logic [7:0] ch;
		logic       valid;
		logic       done;
		logic       found;
		logic [7:0] count;
	} extract_result_t;

	// Tracks the document scan and holds the extraction results still to come
	class value_scoreboard;
		logic [5:0]  key_len;
		logic [63:0] key_words [4];
		logic [8:0]  max_len;
		phase_t      ph;
		int unsigned key_pos;
		bit          key_bad;
		logic [7:0]  char_count;
		bit          finished;
		extract_result_t pending_results [$];
		int          mismatches;

		function new();
			key_len = 6'd1;
			foreach (key_words[i]) key_words[i] = '0;
			max_len = 9'd256;
			mismatches = 0;
			clear_doc();
		endfunction

		function void clear_doc();
			ph = PH_SCAN;
			key_pos = 0;
			key_bad = 0;
			char_count = '0;
			finished = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				REG_KEY_LEN: key_len = val[5:0];
				REG_KEY_B0, REG_KEY_B1, REG_KEY_B2, REG_KEY_B3: key_words[idx - REG_KEY_B0] = val;
				REG_MAX_LEN: max_len = val[8:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] key_char(int unsigned i);
			return key_words[(i >> 3) & 3][8 * (i & 7) +: 8];
		endfunction

		// Clamp capacity to 1..OUT_MAX, drop the terminator, cap at 255
		function logic [7:0] value_limit();
			int unsigned cap;
			cap = max_len;
			if (cap == 0) cap = 1;
			if (cap > OUT_MAX) cap = OUT_MAX;
			cap = cap - 1;
			if (cap > 255) cap = 255;
			return cap[7:0];
		endfunction

		function bit is_blank(logic [7:0] b);
			return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// Advance the scan by one accepted byte and queue its result, if any
		function void note_byte(logic [7:0] b, logic last);
			bit ending, emit, done, klen_ok;
			logic [7:0] ch;
			extract_result_t r;
			ending = (b == CH_NUL) || last;
			emit = 0;
			done = 0;
			ch = '0;
			klen_ok = key_len >= 1 && key_len <= KEY_MAX;
			// Drop everything after the ending result until the document ends
			if (finished) begin
				if (ending) clear_doc();
				return;
			end
			if (b != CH_NUL) begin
				case (ph)
					PH_SCAN: begin
						if (b == CH_QUOTE) begin
							ph = PH_KEY;
							key_pos = 0;
							key_bad = 0;
						end
					end
					PH_KEY: begin
						if (b == CH_QUOTE) begin
							ph = (klen_ok && !key_bad && key_pos == key_len) ? PH_AFTER_KEY : PH_SCAN;
						end else if (klen_ok && key_pos < key_len) begin
							if (b != key_char(key_pos)) key_bad = 1;
							key_pos++;
						end else begin
							key_bad = 1;
						end
					end
					PH_AFTER_KEY: begin
						if (b == CH_COLON) ph = PH_AFTER_COLON;
						else if (!is_blank(b)) ph = PH_SCAN;
					end
					PH_AFTER_COLON: begin
						if (b == CH_QUOTE) begin
							ph = PH_VALUE;
							if (value_limit() == 0) done = 1;
						end else if (!is_blank(b)) begin
							done = 1;
						end
					end
					PH_VALUE: begin
						if (b == CH_QUOTE) done = 1;
						else if (b == CH_BSLASH) ph = PH_ESCAPE;
						else begin
							emit = 1;
							ch = b;
						end
					end
					default: begin
						// Map the escaped byte
						ph = PH_VALUE;
						emit = 1;
						if (b == CH_N) ch = CH_LF;
						else if (b == CH_T) ch = CH_TAB;
						else ch = b;
					end
				endcase
				if (emit) begin
					char_count = char_count + 8'd1;
					if (char_count >= value_limit()) done = 1;
				end
			end
			if (ending) done = 1;
			if (!emit && !done) return;
			r.ch = emit ? ch : 8'h00;
			r.valid = emit;
			r.done = done;
			r.found = (ph == PH_VALUE) || (ph == PH_ESCAPE);
			r.count = char_count;
			pending_results.push_back(r);
			if (ending) clear_doc();
			else finished = done;
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		// Compare one result transaction with the oldest expectation
		function void check_result(logic [15:0] data, logic [1:0] user, logic last);
			extract_result_t r;
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual data %h user %b last %b",
					$time, data, user, last);
				mismatches++;
				return;
			end
			r = pending_results.pop_front();
			compare_field("out_byte", r.ch, data[7:0]);
			compare_field("length", r.count, data[15:8]);
			compare_field("out_valid", r.valid, user[0]);
			compare_field("value_found", r.found, user[1]);
			compare_field("done_res", r.done, last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_KEY_LEN;
	logic [63:0] cfg_wdata = '0;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit long_hold_req = 0;
	int sent_count = 0;
	logic [8:0] doc_q [$];   // {end flag, byte}
	logic [7:0] blanks [4] = '{CH_SP, CH_TAB, CH_LF, CH_CR};
	value_scoreboard sb = new();

	json_key_string_extractor_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Check results first, then note the byte taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
		end
	end

	// Result side: random stalls, plus one long hold-off when requested
	int  hold_cycles = 0;
	bit  long_hold_done = 0;
	always @(posedge clk) begin
		if (long_hold_req && !long_hold_done) begin
			m_axis_tready <= 1'b0;
			hold_cycles++;
			if (hold_cycles >= LONG_HOLD_CYCLES) long_hold_done = 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		do c = 8'($urandom_range(126, 32)); while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	function automatic logic [63:0] text_word();
		logic [63:0] w;
		for (int i = 0; i < 8; i++) w[8 * i +: 8] = text_char();
		return w;
	endfunction

	function automatic void put(logic [7:0] b);
		doc_q.push_back({1'b0, b});
	endfunction

	function automatic void put_text(string s);
		foreach (s[i]) put(s[i]);
	endfunction

	function automatic void put_ws();
		repeat ($urandom_range(2)) put(blanks[$urandom_range(3)]);
	endfunction

	// Quoted token: exact key, prefix, extended key, random text or one byte off
	function automatic void put_token(int kind);
		int n;
		int bad;
		logic [7:0] c;
		put(CH_QUOTE);
		case (kind)
			0, 2: begin
				for (int i = 0; i < sb.key_len; i++) put(sb.key_char(i));
				if (kind == 2) put(text_char());
			end
			1: begin
				n = (sb.key_len > 0) ? $urandom_range(sb.key_len - 1) : 0;
				for (int i = 0; i < n; i++) put(sb.key_char(i));
			end
			3: repeat ($urandom_range(6)) put(text_char());
			default: begin
				bad = (sb.key_len > 0) ? $urandom_range(sb.key_len - 1) : 0;
				for (int i = 0; i < sb.key_len; i++) begin
					c = sb.key_char(i);
					put((i == bad) ? c ^ 8'h01 : c);
				end
			end
		endcase
		put(CH_QUOTE);
	endfunction

	// String value with escapes, mostly short, sometimes left unclosed
	function automatic void put_value();
		int n;
		n = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(8);
		put(CH_QUOTE);
		repeat (n) begin
			if ($urandom_range(4) == 0) begin
				put(CH_BSLASH);
				case ($urandom_range(3))
					0: put(CH_N);
					1: put(CH_T);
					2: put(CH_QUOTE);
					default: put(8'($urandom_range(255, 1)));
				endcase
			end else begin
				put(text_char());
			end
		end
		if ($urandom_range(7) != 0) put(CH_QUOTE);
	endfunction

	// Build one document of key/value segments and noise, with a random ending
	function automatic void build_doc();
		int n;
		doc_q.delete();
		if ($urandom_range(1)) put(CH_LBRACE);
		repeat ($urandom_range(4, 1)) begin
			if ($urandom_range(99) < 10) begin
				repeat ($urandom_range(4, 1)) put(8'($urandom_range(255, 1)));
			end else begin
				put_ws();
				put_token(($urandom_range(99) < 45) ? 0 : $urandom_range(4, 1));
				put_ws();
				if ($urandom_range(99) < 85) put(CH_COLON);
				else if ($urandom_range(1)) put(CH_QUOTE);
				else put(text_char());
				put_ws();
				case ($urandom_range(9))
					7: repeat ($urandom_range(3, 1)) put(CH_DIGIT0 + 8'($urandom_range(9)));
					8: put_token($urandom_range(4));
					9: put(CH_LBRACE);
					default: put_value();
				endcase
				put_ws();
				if ($urandom_range(1)) put(CH_COMMA);
			end
		end
		case ($urandom_range(19))
			12, 13, 14, 15: begin
				put(CH_NUL);
				if ($urandom_range(3) == 0) doc_q[$][8] = 1'b1;
			end
			16, 17: begin
				n = $urandom_range(doc_q.size(), 1);
				while (doc_q.size() > n) void'(doc_q.pop_back());
				doc_q[$][8] = 1'b1;
			end
			18, 19: begin
				put(CH_BSLASH);
				doc_q[$][8] = 1'b1;
			end
			default: doc_q[$][8] = 1'b1;
		endcase
	endfunction

	// Offer one byte after a random gap; return at the accepting edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sent_count++;
	endtask

	task automatic send_doc();
		foreach (doc_q[i]) send_byte(doc_q[i][7:0], doc_q[i][8]);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// Drain the block, let it settle, then write every register
	task automatic configure(input logic [5:0] klen, input logic [63:0] w0, input logic [63:0] w1,
			input logic [63:0] w2, input logic [63:0] w3, input logic [8:0] mlen);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_KEY_LEN, 64'(klen));
		write_reg(REG_KEY_B0, w0);
		write_reg(REG_KEY_B1, w1);
		write_reg(REG_KEY_B2, w2);
		write_reg(REG_KEY_B3, w3);
		write_reg(REG_MAX_LEN, 64'(mlen));
		cfg_we <= 1'b0;
	endtask

	// Key words: 0 printable text, 1 all ones, 2 all zeros, 3 raw random
	task automatic run_phase(input int tx_pct, input int rx_pct, input logic [5:0] klen,
			input logic [8:0] mlen, input int pattern, input int n_items,
			input bit long_value, input bit pause_mid);
		logic [63:0] w [4];
		int start;
		foreach (w[i]) begin
			case (pattern)
				0: w[i] = text_word();
				1: w[i] = '1;
				2: w[i] = '0;
				default: w[i] = {$urandom, $urandom};
			endcase
		end
		configure(klen, w[0], w[1], w[2], w[3], mlen);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		// Value longer than any capacity, sent while the result side holds off
		if (long_value) begin
			long_hold_req = 1;
			doc_q.delete();
			put_token(0);
			put(CH_COLON);
			put(CH_QUOTE);
			repeat (258) put(text_char());
			put(CH_QUOTE);
			doc_q[$][8] = 1'b1;
			send_doc();
		end
		start = sent_count;
		while (sent_count - start < n_items) begin
			build_doc();
			send_doc();
			// Hold the sender once until every expected result is out
			if (pause_mid && sent_count - start >= n_items / 2) begin
				pause_mid = 0;
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: key "k", at most three characters
		configure(6'd1, 64'h6B, '0, '0, '0, 9'd4);
		doc_q.delete();
		put_text("\"kk\"\"k\"");
		put(8'hFF);
		put_text("\"k\":\"\\n\\qz\"");
		put(CH_NUL);
		put_text("\"k\":\"\\");
		doc_q[$][8] = 1'b1;
		send_doc();

		run_phase(0, 0, 6'd1, 9'd256, 0, 150, 0, 0);
		run_phase(84, 0, 6'd32, 9'd1, 0, 150, 0, 0);
		run_phase(0, 84, 6'd5, 9'd0, 0, 150, 0, 0);
		run_phase(6, 6, 6'd8, 9'd511, 1, 150, 0, 0);
		run_phase(0, 0, 6'd3, 9'd256, 0, 150, 1, 0);
		run_phase(84, 0, 6'd0, 9'd5, 2, 150, 0, 0);
		run_phase(0, 84, 6'd63, 9'd2, 3, 150, 0, 0);
		run_phase(6, 6, 6'd12, 9'd9, 0, 150, 0, 1);

		// Wait out the remaining results, then the pipeline latency
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#3_200_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/jkse_pkg.sv
hdl/jkse_front.sv
hdl/jkse_queue.sv
hdl/jkse_back.sv
hdl/json_key_string_extractor_unit.sv
verif/tb_json_key_string_extractor_unit.sv
